// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, ignored while reset is active.
`define CSN_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("cylinder normal assertion failed");

// Check a property on every rising clock edge, including during reset.
`define CSN_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("cylinder normal assertion failed during reset");

`endif

// ===== rtl/core/csn_pkg.sv =====
// Shared constants, widths and types of the cylinder surface normal block.
package csn_pkg;

    // Field formats
    localparam int COORD_WIDTH = 32;
    localparam int AXIS_WIDTH  = 16;
    localparam int RSQ_WIDTH   = 32;
    localparam int RSQ_SHIFT   = 16;
    localparam int R2_WIDTH    = RSQ_WIDTH + RSQ_SHIFT;
    localparam int ROUND_SHIFT = 14;
    localparam int NUM_AXES    = 3;

    // Datapath widths
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int MAG_WIDTH   = COORD_WIDTH + 1;
    localparam int SQ_WIDTH    = 2 * COORD_WIDTH + 1;
    localparam int ROOT_WIDTH  = COORD_WIDTH + 1;
    localparam int RAD_WIDTH   = 2 * ROOT_WIDTH;
    localparam int CMP_WIDTH   = (RAD_WIDTH > R2_WIDTH) ? RAD_WIDTH : R2_WIDTH;
    localparam int REM_WIDTH   = ROOT_WIDTH + 1;
    localparam int TRIAL_WIDTH = ROOT_WIDTH + 3;
    localparam int AMAG_WIDTH  = AXIS_WIDTH;
    localparam int PROD_WIDTH  = AMAG_WIDTH + ROOT_WIDTH;
    localparam int Q_WIDTH     = PROD_WIDTH + 1 - ROUND_SHIFT;
    localparam int A_WIDTH     = Q_WIDTH + 1;
    localparam int N_WIDTH     = ((A_WIDTH > DIFF_WIDTH) ? A_WIDTH : DIFF_WIDTH) + 1;

    // Stream packing
    localparam int BASE_LSB     = NUM_AXES * COORD_WIDTH;
    localparam int AXIS_LSB     = 2 * NUM_AXES * COORD_WIDTH;
    localparam int RSQ_LSB      = AXIS_LSB + NUM_AXES * AXIS_WIDTH;
    localparam int S_FIELDS_W   = RSQ_LSB + RSQ_WIDTH;
    localparam int S_DATA_WIDTH = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W   = NUM_AXES * COORD_WIDTH;
    localparam int M_DATA_WIDTH = ((M_FIELDS_W + 7) / 8) * 8;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
    typedef logic signed [AXIS_WIDTH-1:0]  axis_t;
    typedef logic [RSQ_WIDTH-1:0]          rsq_t;
    typedef logic [ROOT_WIDTH-1:0]         root_t;
    typedef logic [RAD_WIDTH-1:0]          rad_t;

    typedef coord_t [NUM_AXES-1:0] coord3_t;
    typedef diff_t  [NUM_AXES-1:0] diff3_t;
    typedef axis_t  [NUM_AXES-1:0] axis3_t;

    // Per-item values that ride alongside the square root
    typedef struct packed {
        diff3_t d;
        axis3_t ax;
    } side_t;

endpackage

// ===== rtl/core/csn_front.sv =====
// Front pipeline: differences, squares, squared distance and radius clamp.
module csn_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  csn_pkg::coord3_t hit,
    input  csn_pkg::coord3_t base,
    input  csn_pkg::axis3_t  axis,
    input  csn_pkg::rsq_t    radius_sq,
    output logic             out_valid,
    output csn_pkg::rad_t    out_rad,
    output csn_pkg::side_t   out_side
);
    import csn_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg;

    diff3_t d1_reg, d2_reg, d3_reg, d4_reg;
    axis3_t ax1_reg, ax2_reg, ax3_reg, ax4_reg;
    rsq_t   rsq1_reg, rsq2_reg, rsq3_reg;

    diff3_t              d1_next;
    logic [SQ_WIDTH-1:0] sq_next [NUM_AXES];
    logic [SQ_WIDTH-1:0] sq2_reg [NUM_AXES];
    rad_t                sum_next;
    rad_t                sum3_reg;
    rad_t                rad_next;
    rad_t                rad4_reg;

    logic [MAG_WIDTH-1:0]   mag [NUM_AXES];
    logic [2*MAG_WIDTH-1:0] prod [NUM_AXES];
    logic [CMP_WIDTH-1:0]   r2_wide;
    logic [CMP_WIDTH-1:0]   d2_wide;
    logic [CMP_WIDTH-1:0]   diff_wide;

    // Stage 1: sign-extended differences hit - base
    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            d1_next[i] = diff_t'($signed(hit[i])) - diff_t'($signed(base[i]));
        end
    end

    // Stage 2: square the magnitude of each difference
    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            mag[i]     = d1_reg[i][DIFF_WIDTH-1] ? MAG_WIDTH'(-$signed(d1_reg[i]))
                                                 : MAG_WIDTH'(d1_reg[i]);
            prod[i]    = mag[i] * mag[i];
            sq_next[i] = prod[i][SQ_WIDTH-1:0];
        end
    end

    // Stage 3: sum the squares
    assign sum_next = RAD_WIDTH'(sq2_reg[0]) + RAD_WIDTH'(sq2_reg[1]) + RAD_WIDTH'(sq2_reg[2]);

    // Stage 4: subtract the widened squared radius, clamp a negative difference to zero
    always_comb begin
        r2_wide   = CMP_WIDTH'(rsq3_reg) << RSQ_SHIFT;
        d2_wide   = CMP_WIDTH'(sum3_reg);
        diff_wide = d2_wide - r2_wide;
        rad_next  = (d2_wide >= r2_wide) ? diff_wide[RAD_WIDTH-1:0] : '0;
    end

    // Advance the valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Advance the payload
    always_ff @(posedge aclk) begin
        if (en) begin
            d1_reg   <= d1_next;
            ax1_reg  <= axis;
            rsq1_reg <= radius_sq;
            d2_reg   <= d1_reg;
            ax2_reg  <= ax1_reg;
            rsq2_reg <= rsq1_reg;
            for (int i = 0; i < NUM_AXES; i++) begin
                sq2_reg[i] <= sq_next[i];
            end
            d3_reg   <= d2_reg;
            ax3_reg  <= ax2_reg;
            rsq3_reg <= rsq2_reg;
            sum3_reg <= sum_next;
            d4_reg   <= d3_reg;
            ax4_reg  <= ax3_reg;
            rad4_reg <= rad_next;
        end
    end

    assign out_valid   = v4_reg;
    assign out_rad     = rad4_reg;
    assign out_side.d  = d4_reg;
    assign out_side.ax = ax4_reg;

endmodule

// ===== rtl/core/csn_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, with sideband carry.
module csn_isqrt (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  csn_pkg::rad_t  in_rad,
    input  csn_pkg::side_t in_side,
    output logic           out_valid,
    output csn_pkg::root_t out_root,
    output csn_pkg::side_t out_side
);
    import csn_pkg::*;

    localparam int STAGES = ROOT_WIDTH;

    logic                 v_reg    [STAGES];
    root_t                root_reg [STAGES];
    side_t                side_reg [STAGES];
    rad_t                 rad_reg  [STAGES-1];
    logic [REM_WIDTH-1:0] rem_reg  [STAGES-1];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic                   v_cur;
        root_t                  root_cur;
        rad_t                   rad_cur;
        logic [REM_WIDTH-1:0]   rem_cur;
        side_t                  side_cur;
        logic [TRIAL_WIDTH-1:0] rem_sh;
        logic [TRIAL_WIDTH-1:0] trial;
        logic [TRIAL_WIDTH-1:0] rem_sub;
        logic                   take;

        if (k == 0) begin : g_first
            assign v_cur    = in_valid;
            assign root_cur = '0;
            assign rad_cur  = in_rad;
            assign rem_cur  = '0;
            assign side_cur = in_side;
        end else begin : g_rest
            assign v_cur    = v_reg[k-1];
            assign root_cur = root_reg[k-1];
            assign rad_cur  = rad_reg[k-1];
            assign rem_cur  = rem_reg[k-1];
            assign side_cur = side_reg[k-1];
        end

        // Bring down the next two radicand bits and try root*4+1
        assign rem_sh  = {rem_cur, rad_cur[RAD_WIDTH-1 -: 2]};
        assign trial   = TRIAL_WIDTH'({root_cur, 2'b01});
        assign take    = (rem_sh >= trial);
        assign rem_sub = rem_sh - trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_cur;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                root_reg[k] <= {root_cur[ROOT_WIDTH-2:0], take};
                side_reg[k] <= side_cur;
            end
        end

        // Pass the partial remainder and the rest of the radicand on
        if (k < STAGES - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rad_reg[k] <= rad_cur << 2;
                    rem_reg[k] <= take ? rem_sub[REM_WIDTH-1:0] : rem_sh[REM_WIDTH-1:0];
                end
            end
        end
    end

    assign out_valid = v_reg[STAGES-1];
    assign out_root  = root_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];

endmodule

// ===== rtl/core/csn_back.sv =====
// Back pipeline: axis times offset, rounding, subtraction from the difference, saturation.
module csn_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  csn_pkg::root_t   in_root,
    input  csn_pkg::side_t   in_side,
    output logic             out_valid,
    output csn_pkg::coord3_t out_normal
);
    import csn_pkg::*;

    localparam logic [PROD_WIDTH:0] ROUND_HALF =
        {{PROD_WIDTH{1'b0}}, 1'b1} << (ROUND_SHIFT - 1);
    localparam logic signed [N_WIDTH-1:0] SAT_HI =
        {{(N_WIDTH-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [N_WIDTH-1:0] SAT_LO =
        {{(N_WIDTH-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

    logic v1_reg, v2_reg, v3_reg;

    diff3_t d1_reg, d2_reg;

    logic [AMAG_WIDTH-1:0]       amag     [NUM_AXES];
    logic [PROD_WIDTH-1:0]       p_next   [NUM_AXES];
    logic [PROD_WIDTH-1:0]       p1_reg   [NUM_AXES];
    logic                        neg1_reg [NUM_AXES];
    logic [PROD_WIDTH:0]         p_round  [NUM_AXES];
    logic [Q_WIDTH-1:0]          q        [NUM_AXES];
    logic signed [A_WIDTH-1:0]   a_next   [NUM_AXES];
    logic signed [A_WIDTH-1:0]   a2_reg   [NUM_AXES];
    logic signed [N_WIDTH-1:0]   n        [NUM_AXES];
    coord3_t                     nrm_next;
    coord3_t                     nrm3_reg;

    // Stage 1: magnitude of the axis component times the offset
    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            amag[i]   = in_side.ax[i][AXIS_WIDTH-1] ? AMAG_WIDTH'(-$signed(in_side.ax[i]))
                                                    : AMAG_WIDTH'(in_side.ax[i]);
            p_next[i] = PROD_WIDTH'(amag[i]) * PROD_WIDTH'(in_root);
        end
    end

    // Stage 2: round half away from zero, then apply the axis sign
    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            p_round[i] = {1'b0, p1_reg[i]} + ROUND_HALF;
            q[i]       = p_round[i][PROD_WIDTH:ROUND_SHIFT];
            a_next[i]  = neg1_reg[i] ? -$signed({1'b0, q[i]}) : $signed({1'b0, q[i]});
        end
    end

    // Stage 3: subtract from the difference and clamp to the coordinate range
    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            n[i] = N_WIDTH'($signed(d2_reg[i])) - N_WIDTH'(a2_reg[i]);
            if (n[i] > SAT_HI) begin
                nrm_next[i] = COORD_WIDTH'(SAT_HI);
            end else if (n[i] < SAT_LO) begin
                nrm_next[i] = COORD_WIDTH'(SAT_LO);
            end else begin
                nrm_next[i] = COORD_WIDTH'(n[i]);
            end
        end
    end

    // Advance the valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Advance the payload
    always_ff @(posedge aclk) begin
        if (en) begin
            d1_reg <= in_side.d;
            d2_reg <= d1_reg;
            for (int i = 0; i < NUM_AXES; i++) begin
                p1_reg[i]   <= p_next[i];
                neg1_reg[i] <= in_side.ax[i][AXIS_WIDTH-1];
                a2_reg[i]   <= a_next[i];
            end
            nrm3_reg <= nrm_next;
        end
    end

    assign out_valid  = v3_reg;
    assign out_normal = nrm3_reg;

endmodule

// ===== rtl/core/cylinder_surface_normal.sv =====
// Top level of the cylinder surface normal pipeline with its output buffer.
//
// Usage: one input beat on the s_ channel carries a hit point, the cylinder
// base point, the unit axis (Q1.14) and the squared radius; one output beat
// on the m_ channel carries the unnormalized normal hit - (base + axis * t),
// t = floor(sqrt(max(|hit - base|^2 - (radius_sq << 16), 0))), saturated per axis.
// Beats are independent; results leave in the order the beats came in.
// Throughput: one beat per cycle when the receiver is ready. Path: a beat
// passes 4 front stages (difference, square, sum, clamp), 33 square root
// stages (one root bit each, set by the root width), 3 back stages (axis
// product, rounding, saturation) and the output register to m_tvalid.
// Reset: aresetn, synchronous and active low, empties every stage; m_tvalid
// is low and s_tready high on the first cycle after reset.
// Stall: while m_tready is low the result is held on m_tdata and one more
// beat is caught in a skid register; s_tready then drops and the whole
// pipeline freezes until the output is taken. Nothing is lost or repeated.
module cylinder_surface_normal (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // hit_x, hit_y, hit_z, base_x, base_y, base_z, axis_x, axis_y, axis_z, radius_sq
    input  logic [csn_pkg::S_DATA_WIDTH-1:0] s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // normal_x, normal_y, normal_z
    output logic [csn_pkg::M_DATA_WIDTH-1:0] m_tdata
);
    import csn_pkg::*;

    logic    pipe_en;
    logic    in_valid;
    coord3_t hit;
    coord3_t base;
    axis3_t  axis;
    rsq_t    radius_sq;

    logic  front_valid;
    rad_t  front_rad;
    side_t front_side;
    logic  root_valid;
    root_t root_val;
    side_t root_side;
    logic    back_valid;
    coord3_t back_normal;
    logic    take;

    logic    out_v_reg, out_v_next;
    coord3_t out_d_reg, out_d_next;
    logic    skid_v_reg, skid_v_next;
    coord3_t skid_d_reg, skid_d_next;

    // Unpack the input beat
    assign hit       = s_tdata[BASE_LSB-1:0];
    assign base      = s_tdata[AXIS_LSB-1:BASE_LSB];
    assign axis      = s_tdata[RSQ_LSB-1:AXIS_LSB];
    assign radius_sq = s_tdata[RSQ_LSB +: RSQ_WIDTH];

    // Freeze the pipeline only while the skid register holds a beat
    assign pipe_en  = !skid_v_reg;
    assign s_tready = pipe_en;
    assign in_valid = s_tvalid && pipe_en;

    csn_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (in_valid),
        .hit       (hit),
        .base      (base),
        .axis      (axis),
        .radius_sq (radius_sq),
        .out_valid (front_valid),
        .out_rad   (front_rad),
        .out_side  (front_side)
    );

    csn_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (front_valid),
        .in_rad    (front_rad),
        .in_side   (front_side),
        .out_valid (root_valid),
        .out_root  (root_val),
        .out_side  (root_side)
    );

    csn_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (pipe_en),
        .in_valid   (root_valid),
        .in_root    (root_val),
        .in_side    (root_side),
        .out_valid  (back_valid),
        .out_normal (back_normal)
    );

    // Output register and skid: drain the skid first, catch a beat when stalled
    always_comb begin
        out_v_next  = out_v_reg;
        out_d_next  = out_d_reg;
        skid_v_next = skid_v_reg;
        skid_d_next = skid_d_reg;
        take        = back_valid && pipe_en;
        if (!out_v_reg || m_tready) begin
            if (skid_v_reg) begin
                out_v_next  = 1'b1;
                out_d_next  = skid_d_reg;
                skid_v_next = 1'b0;
            end else begin
                out_v_next = take;
                if (take) begin
                    out_d_next = back_normal;
                end
            end
        end else if (take) begin
            skid_v_next = 1'b1;
            skid_d_next = back_normal;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else begin
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_d_reg  <= out_d_next;
        skid_d_reg <= skid_d_next;
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = M_DATA_WIDTH'(out_d_reg);

endmodule

// ===== rtl/core/csn_checker.sv =====
// Port-level checker for the cylinder surface normal block and its bind.
`include "assert_macros.svh"

module csn_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [csn_pkg::S_DATA_WIDTH-1:0] s_tdata,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [csn_pkg::M_DATA_WIDTH-1:0] m_tdata
);
    import csn_pkg::*;

    // Hold a stalled output beat
    `CSN_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid)
    `CSN_ASSERT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata))

    // Drop the output valid after a reset cycle
    `CSN_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid)

    // Refuse input only while a result waits on the output
    `CSN_ASSERT(a_busy_has_out, aclk, aresetn, !s_tready |-> m_tvalid)

    // Lower s_tready only after the output was stalled
    `CSN_ASSERT(a_busy_cause, aclk, aresetn,
        $fell(s_tready) |-> $past(m_tvalid && !m_tready))

endmodule

bind cylinder_surface_normal csn_checker u_csn_checker (.*);

// ===== tb/cylinder_surface_normal_test.sv =====
// Testbench for the cylinder surface normal pipeline: random streams checked against a predictor.
module cylinder_surface_normal_test;
    import csn_pkg::*;

    localparam int CYCLE_LIMIT  = 400_000;
    localparam int DRAIN_CYCLES = 60;
    localparam int REPORT_LIMIT = 10;
    localparam int BEATS_PER_PHASE = 450;
    localparam logic signed [31:0] ONE = 32'sh0001_0000;
    localparam logic signed [15:0] AX_ONE = 16'sh4000;

    // Scoreboard: predicts the normal for each accepted beat and checks results in order
    class normal_scoreboard;
        logic [M_DATA_WIDTH-1:0] normal_q[$];
        int errors = 0;
        int reported = 0;

        // Compute hit - (base + axis * t), t = floor(sqrt(max(D2 - r2, 0))), saturated
        function logic [M_DATA_WIDTH-1:0] normal_of(logic [S_DATA_WIDTH-1:0] beat);
            logic signed [63:0] d [3];
            logic signed [63:0] hv, bv, axv, a, n, hi, lo;
            logic [63:0] m, axm, t, c, q;
            logic [127:0] mq, d2, r2, rem, cq, p;
            logic [M_DATA_WIDTH-1:0] res;
            int i, b;
            d2 = '0;
            res = '0;
            hi = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
            lo = -hi - 64'sd1;
            for (i = 0; i < NUM_AXES; i++) begin
                hv = $signed(beat[i*COORD_WIDTH +: COORD_WIDTH]);
                bv = $signed(beat[BASE_LSB + i*COORD_WIDTH +: COORD_WIDTH]);
                d[i] = hv - bv;
                m = (d[i] < 0) ? -d[i] : d[i];
                mq = {64'b0, m};
                d2 = d2 + mq * mq;
            end
            r2 = {96'b0, beat[RSQ_LSB +: RSQ_WIDTH]};
            r2 = r2 << RSQ_SHIFT;
            rem = (r2 <= d2) ? d2 - r2 : '0;
            // Floor square root, one bit at a time from the top
            t = '0;
            for (b = 63; b >= 0; b--) begin
                c = t | (64'd1 << b);
                cq = {64'b0, c};
                if (cq * cq <= rem)
                    t = c;
            end
            for (i = 0; i < NUM_AXES; i++) begin
                axv = $signed(beat[AXIS_LSB + i*AXIS_WIDTH +: AXIS_WIDTH]);
                axm = (axv < 0) ? -axv : axv;
                // Round the magnitude half away from zero, then apply the sign
                p = {64'b0, axm} * {64'b0, t} + 128'd8192;
                q = p[ROUND_SHIFT +: 64];
                a = q;
                if (axv < 0)
                    a = -a;
                n = d[i] - a;
                if (n > hi)
                    n = hi;
                if (n < lo)
                    n = lo;
                res[i*COORD_WIDTH +: COORD_WIDTH] = n[COORD_WIDTH-1:0];
            end
            return res;
        endfunction

        function void note_input(logic [S_DATA_WIDTH-1:0] beat);
            normal_q.push_back(normal_of(beat));
        endfunction

        function void check_result(logic [M_DATA_WIDTH-1:0] beat);
            logic [M_DATA_WIDTH-1:0] want;
            int i;
            if (normal_q.size() == 0) begin
                errors++;
                if (reported < REPORT_LIMIT) begin
                    reported++;
                    $display("unexpected result beat %h", beat);
                end
                return;
            end
            want = normal_q.pop_front();
            for (i = 0; i < NUM_AXES; i++) begin
                if (beat[i*COORD_WIDTH +: COORD_WIDTH] !== want[i*COORD_WIDTH +: COORD_WIDTH]) begin
                    errors++;
                    if (reported < REPORT_LIMIT) begin
                        reported++;
                        $display("normal[%0d] mismatch: expected %h, actual %h", i,
                                 want[i*COORD_WIDTH +: COORD_WIDTH],
                                 beat[i*COORD_WIDTH +: COORD_WIDTH]);
                    end
                end
            end
        endfunction

        function int pending();
            return normal_q.size();
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_DATA_WIDTH-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_DATA_WIDTH-1:0] m_tdata;

    int idle_pct = 0;
    int stall_pct = 0;
    int cycles = 0;
    normal_scoreboard sb = new;

    cylinder_surface_normal u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    // Stall the receiver at random
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Watch both channels and bound the run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_input(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("cylinder_surface_normal_test: done, errors");
            $finish;
        end
    end

    function automatic logic [S_DATA_WIDTH-1:0] pack_beat(
        input coord_t hx, input coord_t hy, input coord_t hz,
        input coord_t bx, input coord_t by, input coord_t bz,
        input axis_t ax, input axis_t ay, input axis_t az, input rsq_t rsq);
        logic [S_DATA_WIDTH-1:0] beat;
        beat = '0;
        beat[0*COORD_WIDTH +: COORD_WIDTH] = hx;
        beat[1*COORD_WIDTH +: COORD_WIDTH] = hy;
        beat[2*COORD_WIDTH +: COORD_WIDTH] = hz;
        beat[BASE_LSB + 0*COORD_WIDTH +: COORD_WIDTH] = bx;
        beat[BASE_LSB + 1*COORD_WIDTH +: COORD_WIDTH] = by;
        beat[BASE_LSB + 2*COORD_WIDTH +: COORD_WIDTH] = bz;
        beat[AXIS_LSB + 0*AXIS_WIDTH +: AXIS_WIDTH] = ax;
        beat[AXIS_LSB + 1*AXIS_WIDTH +: AXIS_WIDTH] = ay;
        beat[AXIS_LSB + 2*AXIS_WIDTH +: AXIS_WIDTH] = az;
        beat[RSQ_LSB +: RSQ_WIDTH] = rsq;
        return beat;
    endfunction

    // Pick a field value from its corners or at random, w bits wide
    function automatic logic [31:0] corner_bits(input int w);
        logic [31:0] mask;
        mask = (w == 32) ? 32'hFFFF_FFFF : (32'd1 << w) - 32'd1;
        case ($urandom_range(4))
            0: return 32'd1 << (w - 1);
            1: return (32'd1 << (w - 1)) - 32'd1;
            2: return 32'd0;
            3: return mask;
            default: return $urandom & mask;
        endcase
    endfunction

    // Mostly hits near the base with a near-unit axis, plus raw noise and corners
    function automatic logic [S_DATA_WIDTH-1:0] random_beat();
        coord_t hit [3];
        coord_t base [3];
        axis_t ax [3];
        coord_t off;
        int mode, i, j, v;
        rsq_t rsq;
        mode = $urandom_range(99);
        j = $urandom_range(2);
        for (i = 0; i < NUM_AXES; i++) begin
            if (mode < 25) begin
                hit[i] = $urandom;
                base[i] = $urandom;
                ax[i] = axis_t'($urandom);
            end else if (mode < 80) begin
                base[i] = $signed($urandom) >>> 1;
                off = $signed($urandom) >>> $urandom_range(31);
                hit[i] = base[i] + off;
                if (i == j) begin
                    v = 16384 + $urandom_range(64) - 32;
                    if ($urandom_range(1))
                        v = -v;
                end else begin
                    v = $urandom_range(4000) - 2000;
                end
                ax[i] = axis_t'(v);
            end else begin
                hit[i] = corner_bits(COORD_WIDTH);
                base[i] = corner_bits(COORD_WIDTH);
                ax[i] = axis_t'(corner_bits(AXIS_WIDTH));
            end
        end
        if (mode < 25)
            rsq = $urandom;
        else if (mode < 80)
            rsq = $urandom >> $urandom_range(31);
        else
            rsq = corner_bits(RSQ_WIDTH);
        return pack_beat(hit[0], hit[1], hit[2], base[0], base[1], base[2],
                         ax[0], ax[1], ax[2], rsq);
    endfunction

    // Offer one beat, hold it until taken, then idle at random
    task automatic send_beat(input logic [S_DATA_WIDTH-1:0] beat);
        int gap;
        s_tdata <= beat;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        gap = 0;
        while (gap < 40 && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Hold off until every predicted normal has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    task automatic run_phase(input int idle, input int stall);
        int k;
        idle_pct = idle;
        stall_pct <= stall;
        for (k = 0; k < BEATS_PER_PHASE; k++)
            send_beat(random_beat());
        wait_drained();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed beats: zero, on the axis, inside the radius and on its boundary
        send_beat(pack_beat(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_beat(pack_beat(ONE, 0, 0, 0, 0, 0, AX_ONE, 0, 0, 0));
        send_beat(pack_beat(ONE, ONE, 0, 0, 0, 0, 0, 0, AX_ONE, 32'h0004_0000));
        send_beat(pack_beat(2*ONE, 0, 0, 0, 0, 0, 0, AX_ONE, 0, 32'h0004_0000));
        send_beat(pack_beat(2*ONE, 0, 1, 0, 0, 0, 0, AX_ONE, 0, 32'h0004_0000));
        // Hit behind the base still gets a positive offset
        send_beat(pack_beat(-3*ONE, 0, 0, 0, 0, 0, AX_ONE, 0, 0, 0));
        send_beat(pack_beat(0, 5*ONE, 0, ONE, ONE, ONE, 0, -AX_ONE, 0, ONE));
        // Axis far from unit length
        send_beat(pack_beat(7*ONE, -3*ONE, 11, 0, ONE, -ONE,
                            16'sh7FFF, 16'sh8000, 16'sd12345, 32'h0000_0100));
        // Saturate high and low
        send_beat(pack_beat(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                            32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                            16'sh8000, 16'sh8000, 16'sh8000, 0));
        send_beat(pack_beat(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                            32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                            16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0));
        send_beat(pack_beat(32'sh7FFF_FFFF, 0, 0, -1, 0, 0, 0, 0, 0, 0));
        // Largest radius, near and far
        send_beat(pack_beat(ONE, 0, 0, 0, 0, 0, AX_ONE, 0, 0, 32'hFFFF_FFFF));
        send_beat(pack_beat(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 0, 0,
                            0, 0, AX_ONE, 32'hFFFF_FFFF));
        // Hit on the base, and all-ones or all-minimum fields
        send_beat(pack_beat(32'sh7FFF_FFFF, 32'sh8000_0000, -1,
                            32'sh7FFF_FFFF, 32'sh8000_0000, -1,
                            16'sh7FFF, 16'sh8000, 16'shFFFF, 0));
        send_beat(pack_beat(-1, -1, -1, -1, -1, -1,
                            16'shFFFF, 16'shFFFF, 16'shFFFF, 32'hFFFF_FFFF));
        send_beat(pack_beat(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                            32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                            16'sh8000, 16'sh8000, 16'sh8000, 32'hFFFF_FFFF));
        wait_drained();

        // Random traffic under each idling pattern
        run_phase(0, 0);
        run_phase(80, 0);
        run_phase(0, 80);
        run_phase(21, 21);

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("cylinder_surface_normal_test: done, clean");
        else
            $display("cylinder_surface_normal_test: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/csn_pkg.sv
rtl/core/csn_front.sv
rtl/core/csn_isqrt.sv
rtl/core/csn_back.sv
rtl/core/cylinder_surface_normal.sv
rtl/core/csn_checker.sv
tb/cylinder_surface_normal_test.sv
